// ----- design/dvto_pkg.sv -----
// Shared types and constants for the DAG validator / topological orderer.
// Item structs, status codes, register indexes, FSM states, ctrl/datapath bundles.
// No dependencies.
package dvto_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] edge_source;
        logic [7:0] edge_target;
    } t_in_item;

    typedef struct packed {
        logic       is_status;
        logic [2:0] region_index;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SRC_RANGE = 3'd1;
    localparam logic [2:0] ST_DST_RANGE = 3'd2;
    localparam logic [2:0] ST_SELF_LOOP = 3'd3;
    localparam logic [2:0] ST_CYCLE     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // register index = byte address / 4
    localparam int   CFG_ADDR_W       = 3;
    localparam logic REG_REGION_COUNT = 1'b0;
    localparam logic REG_CHECK_CYCLES = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_CNT_RD,
        S_CNT_DEG,
        S_CNT_WR,
        S_SEED_RD,
        S_SEED_CHK,
        S_DRAIN_CHK,
        S_EMIT,
        S_WK_RD,
        S_WK_DEG,
        S_WK_WR,
        S_STATUS
    } t_state;

    typedef struct packed {
        logic load_edge;
        logic run_init;
        logic clr_wr;
        logic edge_rd;
        logic deg_rd_dst;
        logic deg_inc_wr;
        logic seed_rd;
        logic seed_chk;
        logic pop;
        logic emit_node;
        logic dec_wr;
        logic edge_inc;
        logic emit_status;
    } t_cmd;

    typedef struct packed {
        logic fault;
        logic clr_last;
        logic edges_none;
        logic edge_last;
        logic seed_none;
        logic seed_last;
        logic queue_empty;
        logic src_match;
    } t_stat;

endpackage

// ----- design/dag_validate_topo_order.sv -----
// Top level: DAG validator with Kahn topological ordering over loaded edges.
// Holds the APB config registers; instantiates dvto_ctrl and dvto_dpath (dvto_pkg).
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------------
//  input     start & !busy              i_item  {mode, edge_source, edge_target}
//  result    o_valid, one cycle strobe  o_result {is_status, region_index, status, last}
//  config    psel & penable & pwrite    paddr 0: region_count, 4: check_cycles
//
// Sequence: an edge load is taken while idle and busy stays low, so loads stream
//   back to back. An evaluate clears all MAX_REGIONS in-degree entries (S_CLR), counts
//   in-degrees with S_CNT_RD, S_CNT_DEG, S_CNT_WR per stored edge, seeds with S_SEED_RD,
//   S_SEED_CHK per region, then per drained node runs S_DRAIN_CHK, S_EMIT and, per stored
//   edge, S_WK_RD, S_WK_DEG (and S_WK_WR where the edge leaves that node), then a final
//   S_DRAIN_CHK finds the queue empty and S_STATUS follows; a latched fault goes straight
//   to S_STATUS (busy high for a single cycle). Each result strobes on the cycle
//   after the cycle that issues it. The edge store and in-degree memory each do one
//   read and one write per cycle, which sets the per-edge cost.
// Reset: synchronous, active low; edge count and fault clear, region_count = 0,
//   check_cycles = 1. Memories are not cleared.
// Stalls: none on the result side; every result is a one-cycle strobe on o_valid.
module dag_validate_topo_order #(
    parameter int MAX_REGIONS = 8,
    parameter int MAX_EDGES   = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  dvto_pkg::t_in_item             i_item,
    output logic                           o_valid,
    output dvto_pkg::t_out_item            o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dvto_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [3:0] r_region_count;
    logic       r_check_cycles;
    logic       cfg_wr;

    dvto_pkg::t_cmd  cmd;
    dvto_pkg::t_stat stat;

    // config registers; index is paddr[2] (word address)
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_count <= 4'd0;
            r_check_cycles <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == dvto_pkg::REG_REGION_COUNT) begin
                r_region_count <= pwdata[3:0];
            end else begin
                r_check_cycles <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == dvto_pkg::REG_CHECK_CYCLES) begin
            prdata = {31'd0, r_check_cycles};
        end else begin
            prdata = {28'd0, r_region_count};
        end
    end

    dvto_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    dvto_dpath #(
        .MAX_REGIONS (MAX_REGIONS),
        .MAX_EDGES   (MAX_EDGES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_item         (i_item),
        .i_region_count (r_region_count),
        .i_check_cycles (r_check_cycles),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_result       (o_result)
    );

    // order entries only appear mid-run
    a_entry_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.is_status) |-> busy)
        else $error("order entry outside an evaluate run");

    // status item closes the run
    a_status_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.is_status) |-> (!busy && o_result.last))
        else $error("status item without end of run");

    // an accepted evaluate always starts a run
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.mode == dvto_pkg::MODE_EVAL) |=> busy)
        else $error("evaluate did not start a run");

    // loads never produce a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.mode == dvto_pkg::MODE_LOAD) |=> !o_valid)
        else $error("edge load produced a result");

endmodule

// ----- design/dvto_ctrl.sv -----
// Sequencer for edge loads and the Kahn evaluate run.
// Uses dvto_pkg (states, command and status bundles).
module dvto_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mode,
    input  dvto_pkg::t_stat i_stat,
    output dvto_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    dvto_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvto_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            dvto_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_mode == dvto_pkg::MODE_EVAL) begin
                        if (i_stat.fault) begin
                            n_state = dvto_pkg::S_STATUS;
                        end else begin
                            o_cmd.run_init = 1'b1;
                            n_state        = dvto_pkg::S_CLR;
                        end
                    end else begin
                        o_cmd.load_edge = 1'b1;
                    end
                end
            end
            dvto_pkg::S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    if (!i_stat.edges_none) begin
                        n_state = dvto_pkg::S_CNT_RD;
                    end else if (i_stat.seed_none) begin
                        n_state = dvto_pkg::S_DRAIN_CHK;
                    end else begin
                        n_state = dvto_pkg::S_SEED_RD;
                    end
                end
            end
            dvto_pkg::S_CNT_RD: begin
                o_cmd.edge_rd = 1'b1;
                n_state       = dvto_pkg::S_CNT_DEG;
            end
            dvto_pkg::S_CNT_DEG: begin
                o_cmd.deg_rd_dst = 1'b1;
                n_state          = dvto_pkg::S_CNT_WR;
            end
            dvto_pkg::S_CNT_WR: begin
                o_cmd.deg_inc_wr = 1'b1;
                o_cmd.edge_inc   = 1'b1;
                if (!i_stat.edge_last) begin
                    n_state = dvto_pkg::S_CNT_RD;
                end else if (i_stat.seed_none) begin
                    n_state = dvto_pkg::S_DRAIN_CHK;
                end else begin
                    n_state = dvto_pkg::S_SEED_RD;
                end
            end
            dvto_pkg::S_SEED_RD: begin
                o_cmd.seed_rd = 1'b1;
                n_state       = dvto_pkg::S_SEED_CHK;
            end
            dvto_pkg::S_SEED_CHK: begin
                o_cmd.seed_chk = 1'b1;
                n_state = i_stat.seed_last ? dvto_pkg::S_DRAIN_CHK : dvto_pkg::S_SEED_RD;
            end
            dvto_pkg::S_DRAIN_CHK: begin
                if (i_stat.queue_empty) begin
                    n_state = dvto_pkg::S_STATUS;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = dvto_pkg::S_EMIT;
                end
            end
            dvto_pkg::S_EMIT: begin
                o_cmd.emit_node = 1'b1;
                n_state = i_stat.edges_none ? dvto_pkg::S_DRAIN_CHK : dvto_pkg::S_WK_RD;
            end
            dvto_pkg::S_WK_RD: begin
                o_cmd.edge_rd = 1'b1;
                n_state       = dvto_pkg::S_WK_DEG;
            end
            dvto_pkg::S_WK_DEG: begin
                if (i_stat.src_match) begin
                    o_cmd.deg_rd_dst = 1'b1;
                    n_state          = dvto_pkg::S_WK_WR;
                end else begin
                    o_cmd.edge_inc = 1'b1;
                    n_state = i_stat.edge_last ? dvto_pkg::S_DRAIN_CHK : dvto_pkg::S_WK_RD;
                end
            end
            dvto_pkg::S_WK_WR: begin
                o_cmd.dec_wr   = 1'b1;
                o_cmd.edge_inc = 1'b1;
                n_state = i_stat.edge_last ? dvto_pkg::S_DRAIN_CHK : dvto_pkg::S_WK_RD;
            end
            dvto_pkg::S_STATUS: begin
                o_cmd.emit_status = 1'b1;
                n_state           = dvto_pkg::S_IDLE;
            end
            default: begin
                n_state = dvto_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != dvto_pkg::S_IDLE);

endmodule

// ----- design/dvto_dpath.sv -----
// Datapath: edge store, in-degree memory, ready queue, counters, result register.
// Uses dvto_pkg; driven by dvto_ctrl commands.
module dvto_dpath #(
    parameter int MAX_REGIONS = 8,
    parameter int MAX_EDGES   = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dvto_pkg::t_cmd     i_cmd,
    input  dvto_pkg::t_in_item i_item,
    input  logic [3:0]         i_region_count,
    input  logic               i_check_cycles,
    output dvto_pkg::t_stat    o_stat,
    output logic               o_valid,
    output dvto_pkg::t_out_item o_result
);

    localparam int RW  = $clog2(MAX_REGIONS);
    localparam int NW  = $clog2(MAX_REGIONS + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int DW  = ECW;

    typedef struct packed {
        logic [RW-1:0] src;
        logic [RW-1:0] dst;
    } t_edge;

    t_edge         edge_mem  [MAX_EDGES];
    logic [DW-1:0] deg_mem   [MAX_REGIONS];
    logic [RW-1:0] queue_mem [MAX_REGIONS];

    t_edge         r_edge_q;
    logic [DW-1:0] r_deg_q;
    logic [RW-1:0] r_q_q;
    logic [RW-1:0] r_u;

    logic [ECW-1:0] r_ecount;
    logic [2:0]     r_fault;
    logic [EAW-1:0] r_eidx;
    logic [RW-1:0]  r_ridx;
    logic [NW-1:0]  r_head, r_tail, r_drained;
    logic           r_valid;
    dvto_pkg::t_out_item r_result;

    logic [NW-1:0] act_regions;
    logic [2:0]    load_code;
    logic          store_edge;
    logic          deg_we, deg_re, push;
    logic [RW-1:0] deg_wa, deg_ra, push_val;
    logic [DW-1:0] deg_wd;
    logic [2:0]    final_code;
    logic          ridx_last;

    // region count saturates at MAX_REGIONS
    always_comb begin
        if (32'(i_region_count) > MAX_REGIONS) begin
            act_regions = NW'(MAX_REGIONS);
        end else begin
            act_regions = NW'(i_region_count);
        end
    end

    // edge checks in priority order
    always_comb begin
        if (32'(i_item.edge_source) >= 32'(act_regions)) begin
            load_code = dvto_pkg::ST_SRC_RANGE;
        end else if (32'(i_item.edge_target) >= 32'(act_regions)) begin
            load_code = dvto_pkg::ST_DST_RANGE;
        end else if (i_item.edge_source == i_item.edge_target) begin
            load_code = dvto_pkg::ST_SELF_LOOP;
        end else if (32'(r_ecount) >= MAX_EDGES) begin
            load_code = dvto_pkg::ST_OVERFLOW;
        end else begin
            load_code = dvto_pkg::ST_OK;
        end
    end

    assign store_edge = i_cmd.load_edge && (r_fault == dvto_pkg::ST_OK)
                        && (load_code == dvto_pkg::ST_OK);
    assign ridx_last  = (r_ridx == RW'(MAX_REGIONS - 1));

    // in-degree memory ports
    always_comb begin
        deg_we = 1'b0;
        deg_wa = r_ridx;
        deg_wd = '0;
        if (i_cmd.deg_inc_wr) begin
            deg_we = 1'b1;
            deg_wa = r_edge_q.dst;
            deg_wd = r_deg_q + DW'(1);
        end else if (i_cmd.dec_wr && (r_deg_q != '0)) begin
            deg_we = 1'b1;
            deg_wa = r_edge_q.dst;
            deg_wd = r_deg_q - DW'(1);
        end else if (i_cmd.clr_wr) begin
            deg_we = 1'b1;
        end
        deg_re = i_cmd.deg_rd_dst | i_cmd.seed_rd;
        deg_ra = i_cmd.deg_rd_dst ? r_edge_q.dst : r_ridx;
    end

    // ready queue push
    always_comb begin
        push     = 1'b0;
        push_val = r_ridx;
        if (i_cmd.seed_chk && (r_deg_q == '0)) begin
            push = 1'b1;
        end else if (i_cmd.dec_wr && (r_deg_q == DW'(1))) begin
            push     = 1'b1;
            push_val = r_edge_q.dst;
        end
        if (32'(r_tail) >= MAX_REGIONS) begin
            push = 1'b0;
        end
    end

    always_comb begin
        if (r_fault != dvto_pkg::ST_OK) begin
            final_code = r_fault;
        end else if ((r_drained != act_regions) && i_check_cycles) begin
            final_code = dvto_pkg::ST_CYCLE;
        end else begin
            final_code = dvto_pkg::ST_OK;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (store_edge) begin
            edge_mem[r_ecount[EAW-1:0]] <= '{src: RW'(i_item.edge_source),
                                            dst: RW'(i_item.edge_target)};
        end
        if (i_cmd.edge_rd) begin
            r_edge_q <= edge_mem[r_eidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_wa] <= deg_wd;
        end
        if (deg_re) begin
            r_deg_q <= deg_mem[deg_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            queue_mem[r_tail[RW-1:0]] <= push_val;
        end
        if (i_cmd.pop) begin
            r_q_q <= queue_mem[r_head[RW-1:0]];
        end
    end

    // counters and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecount  <= '0;
            r_fault   <= dvto_pkg::ST_OK;
            r_eidx    <= '0;
            r_ridx    <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_drained <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_node | i_cmd.emit_status;
            if (i_cmd.load_edge && (r_fault == dvto_pkg::ST_OK)) begin
                if (load_code != dvto_pkg::ST_OK) begin
                    r_fault <= load_code;
                end else begin
                    r_ecount <= r_ecount + ECW'(1);
                end
            end
            if (i_cmd.emit_status) begin
                r_ecount <= '0;
                r_fault  <= dvto_pkg::ST_OK;
            end
            if (i_cmd.run_init) begin
                r_ridx    <= '0;
                r_eidx    <= '0;
                r_head    <= '0;
                r_tail    <= '0;
                r_drained <= '0;
            end
            if (i_cmd.clr_wr || i_cmd.seed_chk) begin
                r_ridx <= ridx_last ? '0 : r_ridx + RW'(1);
            end
            if (i_cmd.emit_node) begin
                r_eidx    <= '0;
                r_drained <= r_drained + NW'(1);
            end else if (i_cmd.edge_inc) begin
                r_eidx <= r_eidx + EAW'(1);
            end
            if (push) begin
                r_tail <= r_tail + NW'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + NW'(1);
            end
        end
    end

    // result and current node
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_node) begin
            r_u      <= r_q_q;
            r_result <= '{is_status: 1'b0, region_index: 3'(r_q_q),
                          status: dvto_pkg::ST_OK, last: 1'b0};
        end else if (i_cmd.emit_status) begin
            r_result <= '{is_status: 1'b1, region_index: 3'd0,
                          status: final_code, last: 1'b1};
        end
    end

    always_comb begin
        o_stat.fault       = (r_fault != dvto_pkg::ST_OK);
        o_stat.clr_last    = ridx_last;
        o_stat.edges_none  = (r_ecount == '0);
        o_stat.edge_last   = ((ECW'(r_eidx) + ECW'(1)) == r_ecount);
        o_stat.seed_none   = (act_regions == '0);
        o_stat.seed_last   = ((NW'(r_ridx) + NW'(1)) == act_regions);
        o_stat.queue_empty = (r_head == r_tail);
        o_stat.src_match   = (r_edge_q.src == r_u);
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- tb/dag_validate_topo_order_tb.sv -----
// Self-checking testbench for dag_validate_topo_order: edge loads and evaluate runs.
// Predicts the Kahn ordering and status items in-line; depends on dvto_pkg and the RTL.
module dag_validate_topo_order_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_CAP   = 8;
    localparam int N_EDGES    = 64;
    // Quiet cycles before a register write and at the end of the run.
    localparam int SETTLE     = 24;
    // An evaluate over a full edge store leaves long gaps between results;
    // this limit leaves plenty of margin.
    localparam int WDOG_LIMIT = 5000;
    localparam int RAND_ITEMS = 300;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_EVAL,
        ROW_RC,
        ROW_CC
    } t_row_kind;

    // One row of the directed table. For evaluate rows with typed set,
    // want replaces the predicted status of the closing status item.
    typedef struct {
        t_row_kind   kind;
        logic [31:0] a;
        logic [7:0]  b;
        logic        typed;
        logic [2:0]  want;
    } t_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    dvto_pkg::t_in_item  i_item  = '0;
    logic                o_valid;
    dvto_pkg::t_out_item o_result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [dvto_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Typed expectation that travels with the item on the start line.
    logic                typed_valid  = 1'b0;
    logic [2:0]          typed_status = dvto_pkg::ST_OK;

    // Mirror of the block: registers, edge store, latched fault.
    logic [3:0]          rc_reg   = 4'd0;
    logic                cc_reg   = 1'b1;
    logic [2:0]          edge_src [N_EDGES];
    logic [2:0]          edge_dst [N_EDGES];
    int                  edge_cnt = 0;
    logic [2:0]          fault    = dvto_pkg::ST_OK;

    // Order entries and status items still owed by the block, oldest first.
    dvto_pkg::t_out_item pending_results[$];
    t_row                rows[$];

    int                  errors     = 0;
    int                  idle_cycles = 0;

    dag_validate_topo_order #(
        .MAX_REGIONS(NODE_CAP),
        .MAX_EDGES  (N_EDGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic dvto_pkg::t_out_item mk_result(input logic st,
                                                      input logic [2:0] idx,
                                                      input logic [2:0] code,
                                                      input logic lst);
        dvto_pkg::t_out_item r;
        r.is_status    = st;
        r.region_index = idx;
        r.status       = code;
        r.last         = lst;
        return r;
    endfunction

    // Advance the mirror by one accepted item and queue what it produces.
    task automatic topo_sort_step(input dvto_pkg::t_in_item it);
        int         n;
        int         head;
        int         tail;
        int         drained;
        int         indeg [NODE_CAP];
        logic [2:0] ready_q [NODE_CAP];
        logic [2:0] u;
        logic [2:0] code;
        n = (rc_reg > NODE_CAP) ? NODE_CAP : rc_reg;
        if (it.mode == dvto_pkg::MODE_LOAD) begin
            // first fault wins; later loads are dropped until evaluate
            if (fault == dvto_pkg::ST_OK) begin
                if (it.edge_source >= n)
                    fault = dvto_pkg::ST_SRC_RANGE;
                else if (it.edge_target >= n)
                    fault = dvto_pkg::ST_DST_RANGE;
                else if (it.edge_source == it.edge_target)
                    fault = dvto_pkg::ST_SELF_LOOP;
                else if (edge_cnt >= N_EDGES)
                    fault = dvto_pkg::ST_OVERFLOW;
                else begin
                    edge_src[edge_cnt] = it.edge_source[2:0];
                    edge_dst[edge_cnt] = it.edge_target[2:0];
                    edge_cnt++;
                end
            end
        end else begin
            if (fault != dvto_pkg::ST_OK) begin
                pending_results = {pending_results, mk_result(1'b1, 3'd0, fault, 1'b1)};
            end else begin
                head    = 0;
                tail    = 0;
                drained = 0;
                for (int i = 0; i < NODE_CAP; i++)
                    indeg[i] = 0;
                for (int e = 0; e < edge_cnt; e++)
                    indeg[edge_dst[e]]++;
                // seed in ascending region order
                for (int i = 0; i < n; i++)
                    if (indeg[i] == 0 && tail < NODE_CAP) begin
                        ready_q[tail] = i[2:0];
                        tail++;
                    end
                while (head != tail && head < NODE_CAP) begin
                    u = ready_q[head];
                    head++;
                    drained++;
                    pending_results = {pending_results,
                                       mk_result(1'b0, u, dvto_pkg::ST_OK, 1'b0)};
                    for (int e = 0; e < edge_cnt; e++)
                        if (edge_src[e] == u && indeg[edge_dst[e]] > 0) begin
                            indeg[edge_dst[e]]--;
                            if (indeg[edge_dst[e]] == 0 && tail < NODE_CAP) begin
                                ready_q[tail] = edge_dst[e];
                                tail++;
                            end
                        end
                end
                code = (drained != n && cc_reg) ? dvto_pkg::ST_CYCLE : dvto_pkg::ST_OK;
                pending_results = {pending_results, mk_result(1'b1, 3'd0, code, 1'b1)};
            end
            edge_cnt = 0;
            fault    = dvto_pkg::ST_OK;
        end
    endtask

    task automatic cmp_field(input string f, input logic [2:0] want_v,
                             input logic [2:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, f, want_v, got_v);
        end
    endtask

    // Monitor: results first (they belong to earlier items), then the item
    // and register write taken at this edge. Also feeds the watchdog.
    always @(posedge i_clk) begin
        dvto_pkg::t_out_item want;
        dvto_pkg::t_out_item tmp;
        logic      hit;
        hit = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                hit = 1'b1;
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
                end else begin
                    want = pending_results.pop_front();
                    cmp_field("is_status",    {2'b00, want.is_status}, {2'b00, o_result.is_status});
                    cmp_field("region_index", want.region_index,       o_result.region_index);
                    cmp_field("status",       want.status,             o_result.status);
                    cmp_field("last",         {2'b00, want.last},      {2'b00, o_result.last});
                end
            end
            if (start && !busy) begin
                hit = 1'b1;
                topo_sort_step(i_item);
                if (typed_valid) begin
                    tmp        = pending_results[pending_results.size() - 1];
                    tmp.status = typed_status;
                    pending_results[pending_results.size() - 1] = tmp;
                end
            end
            if (psel && penable && pwrite && pready) begin
                hit = 1'b1;
                if (paddr[2] == dvto_pkg::REG_REGION_COUNT)
                    rc_reg = pwdata[3:0];
                else
                    cc_reg = pwdata[0];
            end
            idle_cycles <= hit ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: too long with nothing accepted on any port.
    initial begin
        wait (idle_cycles >= WDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Present one item after gap idle cycles and hold it until taken.
    // start stays high afterwards so a zero-gap item follows back to back.
    task automatic send_item(input dvto_pkg::t_in_item it, input int gap, input logic tv,
                             input logic [2:0] ts);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_item       <= it;
        typed_valid  <= tv;
        typed_status <= ts;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and wait until every owed result is in and the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_idx, input logic [31:0] data);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_row(input t_row_kind k, input logic [31:0] a, input logic [7:0] b,
                           input logic typed, input logic [2:0] want);
        t_row r;
        r.kind  = k;
        r.a     = a;
        r.b     = b;
        r.typed = typed;
        r.want  = want;
        rows = {rows, r};
    endtask

    initial begin
        dvto_pkg::t_in_item it;
        int         sent;
        int         phase;
        int         n_eff;
        int         loads;
        int         r;
        int         j;
        int         tmp_p;
        int         perm [NODE_CAP];
        logic [3:0] rc;
        logic [2:0] s;
        logic [2:0] d;
        logic [2:0] t3;
        bit         burst;
        bit         dag;

        // Directed table. Typed status only where it is obvious.
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_OK);        // after reset: no regions
        add_row(ROW_LOAD, 0,   0,   0, dvto_pkg::ST_OK);        // any source out of range
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_SRC_RANGE);
        add_row(ROW_RC,   8,   0,   0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 255, 255, 0, dvto_pkg::ST_OK);        // extremes, source first
        add_row(ROW_LOAD, 0,   1,   0, dvto_pkg::ST_OK);        // dropped: fault latched
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_SRC_RANGE);
        add_row(ROW_LOAD, 7,   255, 0, dvto_pkg::ST_OK);        // top source, bad target
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_DST_RANGE);
        add_row(ROW_LOAD, 3,   3,   0, dvto_pkg::ST_OK);        // self-loop
        add_row(ROW_LOAD, 1,   2,   0, dvto_pkg::ST_OK);
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_SELF_LOOP);
        add_row(ROW_LOAD, 0,   1,   0, dvto_pkg::ST_OK);        // chain plus a side edge
        add_row(ROW_LOAD, 1,   2,   0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 2,   7,   0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 6,   5,   0, dvto_pkg::ST_OK);
        add_row(ROW_EVAL, 0,   0,   0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 1,   2,   0, dvto_pkg::ST_OK);        // two-node cycle, checking on
        add_row(ROW_LOAD, 2,   1,   0, dvto_pkg::ST_OK);
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_CYCLE);
        add_row(ROW_CC,   32'hFFFF_FFFE, 0, 0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 4,   5,   0, dvto_pkg::ST_OK);        // two-node cycle, checking off
        add_row(ROW_LOAD, 5,   4,   0, dvto_pkg::ST_OK);
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_OK);
        add_row(ROW_RC,   32'hFFFF_FFFF, 0, 0, dvto_pkg::ST_OK); // 15 saturates to 8
        add_row(ROW_LOAD, 7,   0,   0, dvto_pkg::ST_OK);
        add_row(ROW_LOAD, 8,   0,   0, dvto_pkg::ST_OK);        // first index past saturation
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_SRC_RANGE);
        add_row(ROW_CC,   1,   0,   0, dvto_pkg::ST_OK);
        add_row(ROW_RC,   1,   0,   0, dvto_pkg::ST_OK);
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_OK);        // single region drains alone
        add_row(ROW_LOAD, 0,   0,   0, dvto_pkg::ST_OK);        // in range but self-loop
        add_row(ROW_EVAL, 0,   0,   1, dvto_pkg::ST_SELF_LOOP);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            case (rows[k].kind)
                ROW_RC: begin
                    cfg_write(dvto_pkg::REG_REGION_COUNT, rows[k].a);
                end
                ROW_CC: begin
                    cfg_write(dvto_pkg::REG_CHECK_CYCLES, rows[k].a);
                end
                ROW_LOAD: begin
                    it.mode        = dvto_pkg::MODE_LOAD;
                    it.edge_source = rows[k].a[7:0];
                    it.edge_target = rows[k].b;
                    send_item(it, $urandom_range(0, 9), 1'b0, dvto_pkg::ST_OK);
                end
                default: begin
                    // source/target are don't-care on evaluate: randomize them
                    it.mode        = dvto_pkg::MODE_EVAL;
                    it.edge_source = 8'($urandom);
                    it.edge_target = 8'($urandom);
                    send_item(it, $urandom_range(0, 9), rows[k].typed, rows[k].want);
                end
            endcase
        end

        // Random part: phases of a few load/evaluate sequences under one setting.
        // Most loads are legal edges, often ordered along a random permutation so
        // the graph is acyclic and drains fully; the rest are faults and noise.
        sent  = 0;
        phase = 0;
        rc    = rc_reg;
        while (sent < RAND_ITEMS) begin
            if (phase % 3 == 0) begin
                case ($urandom_range(0, 9))
                    0:       rc = 4'd0;
                    1:       rc = 4'($urandom_range(9, 15));
                    2:       rc = 4'd1;
                    default: rc = 4'($urandom_range(2, 8));
                endcase
                if (phase == 0)
                    rc = 4'd8;
                cfg_write(dvto_pkg::REG_REGION_COUNT, ($urandom & 32'hFFFF_FFF0) | 32'(rc));
                if (phase == 0 || $urandom_range(0, 1) == 1)
                    cfg_write(dvto_pkg::REG_CHECK_CYCLES,
                              ($urandom & 32'hFFFF_FFFE) | $urandom_range(0, 1));
            end
            n_eff = (rc > NODE_CAP) ? NODE_CAP : rc;
            burst = ($urandom_range(0, 3) == 0);
            dag   = ($urandom_range(0, 2) != 0);

            // Full store: phase 1 always overflows; later fills stop at 64 or overflow.
            if (phase == 1)
                loads = N_EDGES + 1;
            else if (n_eff >= 2 && $urandom_range(0, 29) == 0)
                loads = N_EDGES + int'($urandom_range(0, 1));
            else
                loads = int'($urandom_range(0, 12));

            for (int i = 0; i < NODE_CAP; i++)
                perm[i] = i;
            for (int i = NODE_CAP - 1; i > 0; i--) begin
                j       = int'($urandom_range(0, i));
                tmp_p   = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp_p;
            end

            for (int l = 0; l < loads; l++) begin
                it.mode = dvto_pkg::MODE_LOAD;
                r       = int'($urandom_range(0, 19));
                if (n_eff < 2 || (r == 0 && loads <= 12)) begin
                    it.edge_source = 8'($urandom);
                    it.edge_target = 8'($urandom);
                end else if (r == 1 && loads <= 12) begin
                    s              = 3'($urandom_range(0, n_eff - 1));
                    it.edge_source = {5'd0, s};
                    it.edge_target = {5'd0, s};
                end else begin
                    s = 3'($urandom_range(0, n_eff - 1));
                    d = 3'($urandom_range(0, n_eff - 2));
                    if (d >= s)
                        d = d + 3'd1;
                    if (dag && perm[s] > perm[d]) begin
                        t3 = s;
                        s  = d;
                        d  = t3;
                    end
                    it.edge_source = {5'd0, s};
                    it.edge_target = {5'd0, d};
                end
                send_item(it, burst ? 0 : $urandom_range(0, 9), 1'b0, dvto_pkg::ST_OK);
                sent++;
            end

            it.mode        = dvto_pkg::MODE_EVAL;
            it.edge_source = 8'($urandom);
            it.edge_target = 8'($urandom);
            send_item(it, burst ? 0 : $urandom_range(0, 9), 1'b0, dvto_pkg::ST_OK);
            sent++;

            // now and then hold the next item until the run has fully drained
            if ($urandom_range(0, 7) == 0)
                drain_results();
            phase++;
        end

        drain_results();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
